// ===== sv/ggvc_pkg.sv =====
// Types and constants for the go-to-goal velocity controller.
// No dependencies; used by the top level datapath and the bench.
package ggvc_pkg;

  localparam int CFG_IW     = 3;
  localparam int CFG_DW     = 16;
  localparam int XW         = 28;
  localparam int ZW         = 20;
  localparam int RMW        = 33;
  localparam int RW         = 34;
  localparam int SQRT_STEPS = 17;
  localparam int ATAN_LEN   = 24;
  localparam int EW         = 25;

  localparam logic [CFG_IW-1:0] REG_TARGET_X     = 3'd0;
  localparam logic [CFG_IW-1:0] REG_TARGET_Y     = 3'd1;
  localparam logic [CFG_IW-1:0] REG_ANGULAR_GAIN = 3'd2;
  localparam logic [CFG_IW-1:0] REG_LINEAR_GAIN  = 3'd3;
  localparam logic [CFG_IW-1:0] REG_ARRIVE_THR   = 3'd4;

  localparam logic [15:0] RST_ANGULAR_GAIN = 16'd6554;
  localparam logic [15:0] RST_LINEAR_GAIN  = 16'd819;
  localparam logic [15:0] RST_ARRIVE_THR   = 16'd26;

  localparam logic signed [ZW-1:0] HALF_PI_Q16 = 20'sd102944;

  localparam logic [16:0] ATAN_Q16 [ATAN_LEN] = '{
    17'd51472, 17'd30386, 17'd16055, 17'd8150, 17'd4091, 17'd2047, 17'd1024, 17'd512,
    17'd256, 17'd128, 17'd64, 17'd32, 17'd16, 17'd8, 17'd4, 17'd2,
    17'd1, 17'd0, 17'd0, 17'd0, 17'd0, 17'd0, 17'd0, 17'd0
  };

  typedef struct packed {
    logic signed [XW-1:0] x;
    logic signed [XW-1:0] y;
    logic signed [ZW-1:0] z;
    logic [RMW-1:0]       rem;
    logic [RW-1:0]        root;
    logic signed [15:0]   hd;
    logic                 zero;
  } step_t;

endpackage

// ===== sv/ggvc_pose_if.sv =====
// Pose request channel: valid, ready and the measured pose.
// No dependencies.
interface ggvc_pose_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] pose_x;
  logic signed [15:0] pose_y;
  logic signed [15:0] pose_heading;

  modport source (output valid, pose_x, pose_y, pose_heading, input ready);
  modport sink   (input valid, pose_x, pose_y, pose_heading, output ready);
endinterface

// ===== sv/ggvc_cmd_if.sv =====
// Command request channel: valid, ready and the velocity command.
// No dependencies.
interface ggvc_cmd_if;
  logic               valid;
  logic               ready;
  logic signed [15:0] angular_rate;
  logic [15:0]        linear_speed;
  logic               arrived;

  modport source (output valid, angular_rate, linear_speed, arrived, input ready);
  modport sink   (input valid, angular_rate, linear_speed, arrived, output ready);
endinterface

// ===== sv/go_to_goal_velocity_controller.sv =====
// Go-to-goal proportional velocity controller: pipelined CORDIC bearing,
// pipelined digit-by-digit distance, gain stages. Uses ggvc_pkg, ggvc_pose_if, ggvc_cmd_if.
//
//   channel   dir   handshake          payload
//   pose_i    in    valid/ready        pose_x, pose_y, pose_heading
//   cmd_o     out   valid/ready        angular_rate, linear_speed, arrived
//   cfg       in    cfg_we_i           cfg_idx_i, cfg_data_i
//
// One pose per cycle sustained while cmd_o is ready; the step chain is as long as the longer
// of the CORDIC chain and the 17-step square root chain.
// Each stage holds its request while the next is full, so stalls lose nothing.
// Reset clears all valid bits and loads the register reset values.
module go_to_goal_velocity_controller
  import ggvc_pkg::*;
#(
  parameter int CORDIC_STAGES = 16
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [CFG_IW-1:0] cfg_idx_i,
  input  logic [CFG_DW-1:0] cfg_data_i,
  ggvc_pose_if.sink         pose_i,
  ggvc_cmd_if.source        cmd_o
);

  localparam int NCORD = (CORDIC_STAGES < ATAN_LEN) ? CORDIC_STAGES : ATAN_LEN;
  localparam int NSTEP = (NCORD > SQRT_STEPS) ? NCORD : SQRT_STEPS;

  logic signed [15:0] tx_q, ty_q;
  logic [15:0]        ag_q, lg_q, thr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tx_q  <= '0;
      ty_q  <= '0;
      ag_q  <= RST_ANGULAR_GAIN;
      lg_q  <= RST_LINEAR_GAIN;
      thr_q <= RST_ARRIVE_THR;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_TARGET_X:     tx_q  <= cfg_data_i;
        REG_TARGET_Y:     ty_q  <= cfg_data_i;
        REG_ANGULAR_GAIN: ag_q  <= cfg_data_i;
        REG_LINEAR_GAIN:  lg_q  <= cfg_data_i;
        REG_ARRIVE_THR:   thr_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // ready chain
  logic s1_rdy, s2_rdy, p1_rdy, p2_rdy, p3_rdy;
  logic st_rdy [NSTEP+2];

  // stage 1: differences
  logic               s1_v_q;
  logic signed [16:0] s1_dx_q, s1_dy_q, s1_dx_d, s1_dy_d;
  logic signed [15:0] s1_hd_q;

  assign s1_rdy       = !s1_v_q || s2_rdy;
  assign pose_i.ready = s1_rdy;
  assign s1_dx_d      = {tx_q[15], tx_q} - {pose_i.pose_x[15], pose_i.pose_x};
  assign s1_dy_d      = {ty_q[15], ty_q} - {pose_i.pose_y[15], pose_i.pose_y};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (s1_rdy) begin
      s1_v_q <= pose_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_rdy && pose_i.valid) begin
      s1_dx_q <= s1_dx_d;
      s1_dy_q <= s1_dy_d;
      s1_hd_q <= pose_i.pose_heading;
    end
  end

  // stage 2: squares and quadrant pre-rotation
  logic                 s2_v_q;
  logic [31:0]          s2_dxx_q, s2_dyy_q;
  logic signed [33:0]   s2_dxx_d, s2_dyy_d;
  logic signed [XW-1:0] s2_x_q, s2_y_q, s2_x_d, s2_y_d, s2_xs, s2_ys;
  logic signed [ZW-1:0] s2_z_q, s2_z_d;
  logic signed [15:0]   s2_hd_q;
  logic                 s2_zero_q;

  assign s2_rdy = !s2_v_q || st_rdy[0];

  always_comb begin
    s2_dxx_d = s1_dx_q * s1_dx_q;
    s2_dyy_d = s1_dy_q * s1_dy_q;
    s2_xs    = {{(XW-25){s1_dx_q[16]}}, s1_dx_q, 8'd0};
    s2_ys    = {{(XW-25){s1_dy_q[16]}}, s1_dy_q, 8'd0};
    s2_x_d   = s2_xs;
    s2_y_d   = s2_ys;
    s2_z_d   = '0;
    if (s1_dx_q[16]) begin
      if (!s1_dy_q[16]) begin
        s2_x_d = s2_ys;
        s2_y_d = -s2_xs;
        s2_z_d = HALF_PI_Q16;
      end else begin
        s2_x_d = -s2_ys;
        s2_y_d = s2_xs;
        s2_z_d = -HALF_PI_Q16;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q <= 1'b0;
    end else if (s2_rdy) begin
      s2_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_rdy && s1_v_q) begin
      s2_dxx_q  <= s2_dxx_d[31:0];
      s2_dyy_q  <= s2_dyy_d[31:0];
      s2_x_q    <= s2_x_d;
      s2_y_q    <= s2_y_d;
      s2_z_q    <= s2_z_d;
      s2_hd_q   <= s1_hd_q;
      s2_zero_q <= (s1_dx_q == '0) && (s1_dy_q == '0);
    end
  end

  // step chain: element 0 holds the sum of squares, elements 1..NSTEP the steps
  step_t st_q [NSTEP+1];
  logic  st_v_q [NSTEP+1];
  step_t st0_d;

  assign st_rdy[NSTEP+1] = p1_rdy;

  always_comb begin
    st0_d.x    = s2_x_q;
    st0_d.y    = s2_y_q;
    st0_d.z    = s2_z_q;
    st0_d.rem  = {1'b0, s2_dxx_q} + {1'b0, s2_dyy_q};
    st0_d.root = '0;
    st0_d.hd   = s2_hd_q;
    st0_d.zero = s2_zero_q;
  end

  for (genvar k = 0; k <= NSTEP; k++) begin : g_rdy
    assign st_rdy[k] = !st_v_q[k] || st_rdy[k+1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_v_q[0] <= 1'b0;
    end else if (st_rdy[0]) begin
      st_v_q[0] <= s2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_rdy[0] && s2_v_q) begin
      st_q[0] <= st0_d;
    end
  end

  for (genvar k = 0; k < NSTEP; k++) begin : g_step
    localparam int SH = (k < SQRT_STEPS) ? 2 * (SQRT_STEPS - 1 - k) : 0;
    localparam logic [RW-1:0] BIT = RW'(1) << SH;
    step_t         nxt;
    logic [RW-1:0] trial;

    always_comb begin
      nxt   = st_q[k];
      trial = st_q[k].root + BIT;
      if (k < NCORD) begin
        if (!st_q[k].y[XW-1]) begin
          nxt.x = st_q[k].x + (st_q[k].y >>> k);
          nxt.y = st_q[k].y - (st_q[k].x >>> k);
          nxt.z = st_q[k].z + ZW'(ATAN_Q16[k]);
        end else begin
          nxt.x = st_q[k].x - (st_q[k].y >>> k);
          nxt.y = st_q[k].y + (st_q[k].x >>> k);
          nxt.z = st_q[k].z - ZW'(ATAN_Q16[k]);
        end
      end
      if (k < SQRT_STEPS) begin
        if ({1'b0, st_q[k].rem} >= trial) begin
          nxt.rem  = st_q[k].rem - trial[RMW-1:0];
          nxt.root = (st_q[k].root >> 1) + BIT;
        end else begin
          nxt.root = st_q[k].root >> 1;
        end
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        st_v_q[k+1] <= 1'b0;
      end else if (st_rdy[k+1]) begin
        st_v_q[k+1] <= st_v_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (st_rdy[k+1] && st_v_q[k]) begin
        st_q[k+1] <= nxt;
      end
    end
  end

  // post 1: heading error, distance, arrival
  logic                 p1_v_q, p1_arr_q;
  logic signed [EW-1:0] p1_err_q, p1_err_d, p1_bear, p1_hds;
  logic [16:0]          p1_dist_q;

  assign p1_rdy  = !p1_v_q || p2_rdy;
  assign p1_bear = st_q[NSTEP].zero ? '0 : EW'(st_q[NSTEP].z);
  assign p1_hds  = {st_q[NSTEP].hd[15], st_q[NSTEP].hd, 8'd0};
  assign p1_err_d = p1_bear - p1_hds;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_v_q <= 1'b0;
    end else if (p1_rdy) begin
      p1_v_q <= st_v_q[NSTEP];
    end
  end

  always_ff @(posedge clk_i) begin
    if (p1_rdy && st_v_q[NSTEP]) begin
      p1_err_q  <= p1_err_d;
      p1_dist_q <= st_q[NSTEP].root[16:0];
      p1_arr_q  <= st_q[NSTEP].root[16:0] < {1'b0, thr_q};
    end
  end

  // post 2: gain products
  logic               p2_v_q, p2_arr_q;
  logic signed [41:0] p2_ang_q, p2_ang_d;
  logic [32:0]        p2_spd_q;
  logic signed [16:0] p2_gain;

  assign p2_rdy   = !p2_v_q || p3_rdy;
  assign p2_gain  = {1'b0, ag_q};
  assign p2_ang_d = p2_gain * p1_err_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p2_v_q <= 1'b0;
    end else if (p2_rdy) begin
      p2_v_q <= p1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (p2_rdy && p1_v_q) begin
      p2_ang_q <= p2_ang_d;
      p2_spd_q <= lg_q * p1_dist_q;
      p2_arr_q <= p1_arr_q;
    end
  end

  // post 3: round, saturate, output register
  logic               p3_v_q, p3_arr_q;
  logic signed [15:0] p3_ang_q, p3_ang_d;
  logic [15:0]        p3_spd_q, p3_spd_d;
  logic signed [41:0] p3_ang_sum;
  logic signed [17:0] p3_ang_sh;
  logic [33:0]        p3_spd_sum;

  assign p3_rdy = !p3_v_q || cmd_o.ready;

  always_comb begin
    p3_ang_sum = p2_ang_q + 42'sd8388608;
    p3_ang_sh  = p3_ang_sum[41:24];
    if (p3_ang_sh > 18'sd32767) begin
      p3_ang_d = 16'sd32767;
    end else if (p3_ang_sh < -18'sd32768) begin
      p3_ang_d = -16'sd32768;
    end else begin
      p3_ang_d = p3_ang_sh[15:0];
    end
    p3_spd_sum = {1'b0, p2_spd_q} + 34'd32768;
    p3_spd_d   = (p3_spd_sum[33:32] != 2'd0) ? 16'hFFFF : p3_spd_sum[31:16];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p3_v_q <= 1'b0;
    end else if (p3_rdy) begin
      p3_v_q <= p2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (p3_rdy && p2_v_q) begin
      p3_ang_q <= p3_ang_d;
      p3_spd_q <= p3_spd_d;
      p3_arr_q <= p2_arr_q;
    end
  end

  assign cmd_o.valid        = p3_v_q;
  assign cmd_o.angular_rate = p3_ang_q;
  assign cmd_o.linear_speed = p3_spd_q;
  assign cmd_o.arrived      = p3_arr_q;

endmodule

// ===== bench/ggvc_bench_pkg.sv =====
// Pose/command types and the command scoreboard for the go-to-goal controller bench.
// Depends on ggvc_pkg for the register indexes and the configuration port widths.
`timescale 1ns / 100ps
package ggvc_bench_pkg;
  import ggvc_pkg::*;

  localparam int CORDIC_DEPTH = 16;
  localparam int PIPE_LATENCY = (CORDIC_DEPTH > 17 ? CORDIC_DEPTH : 17) + 6;
  localparam longint QUARTER_TURN_Q16 = 102944;
  localparam int ARCTAN_LEN = 24;
  localparam longint ARCTAN_Q16 [ARCTAN_LEN] = '{
    51472, 30386, 16055, 8150, 4091, 2047, 1024, 512,
    256, 128, 64, 32, 16, 8, 4, 2,
    1, 0, 0, 0, 0, 0, 0, 0
  };
  localparam longint RATE_MAX = 32767;
  localparam longint RATE_MIN = -32768;
  localparam longint SPEED_MAX = 65535;

  typedef struct packed {
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic signed [15:0] heading;
  } pose_t;

  typedef struct packed {
    logic signed [15:0] rate;
    logic [15:0]        speed;
    logic               arrived;
  } cmd_t;

  class ggvc_scoreboard;
    logic signed [15:0] tgt_x;
    logic signed [15:0] tgt_y;
    logic [15:0]        ang_gain;
    logic [15:0]        lin_gain;
    logic [15:0]        arrive_thr;
    cmd_t               pending_cmds[$];
    int                 n_poses;
    int                 n_cmds;
    int                 n_errors;
    int                 n_arrived;
    int                 n_rate_sat;
    int                 n_speed_sat;

    function new();
      tgt_x      = '0;
      tgt_y      = '0;
      ang_gain   = RST_ANGULAR_GAIN;
      lin_gain   = RST_LINEAR_GAIN;
      arrive_thr = RST_ARRIVE_THR;
      n_poses    = 0;
      n_cmds     = 0;
      n_errors   = 0;
      n_arrived  = 0;
      n_rate_sat = 0;
      n_speed_sat = 0;
    endfunction

    function void write_reg(logic [CFG_IW-1:0] idx, logic [CFG_DW-1:0] data);
      case (idx)
        REG_TARGET_X:     tgt_x = data;
        REG_TARGET_Y:     tgt_y = data;
        REG_ANGULAR_GAIN: ang_gain = data;
        REG_LINEAR_GAIN:  lin_gain = data;
        REG_ARRIVE_THR:   arrive_thr = data;
        default: ;
      endcase
    endfunction

    function cmd_t steer_command(pose_t p);
      longint dx, dy, x, y, z, xs, ys, t, err, ang, sum, root, probe, spd;
      int     i;
      cmd_t   c;
      dx = longint'(tgt_x) - longint'(p.x);
      dy = longint'(tgt_y) - longint'(p.y);
      // bearing by vectoring CORDIC, pre-rotated into the right half plane
      z = 0;
      if (dx != 0 || dy != 0) begin
        x = dx * 256;
        y = dy * 256;
        if (x < 0) begin
          if (y >= 0) begin
            t = y; y = -x; x = t; z = QUARTER_TURN_Q16;
          end else begin
            t = -y; y = x; x = t; z = -QUARTER_TURN_Q16;
          end
        end
        for (i = 0; i < CORDIC_DEPTH && i < ARCTAN_LEN; i++) begin
          xs = x >>> i;
          ys = y >>> i;
          if (y >= 0) begin
            x = x + ys; y = y - xs; z = z + ARCTAN_Q16[i];
          end else begin
            x = x - ys; y = y + xs; z = z - ARCTAN_Q16[i];
          end
        end
      end
      err = z - longint'(p.heading) * 256;
      ang = (longint'(ang_gain) * err + (longint'(1) <<< 23)) >>> 24;
      if (ang > RATE_MAX) ang = RATE_MAX;
      if (ang < RATE_MIN) ang = RATE_MIN;
      // distance by digit-by-digit square root
      sum = dx * dx + dy * dy;
      root = 0;
      probe = longint'(1) << 34;
      while (probe > sum) probe = probe >> 2;
      while (probe != 0) begin
        if (sum >= root + probe) begin
          sum = sum - (root + probe);
          root = (root >> 1) + probe;
        end else begin
          root = root >> 1;
        end
        probe = probe >> 2;
      end
      spd = (longint'(lin_gain) * root + (longint'(1) << 15)) >> 16;
      if (spd > SPEED_MAX) spd = SPEED_MAX;
      c.rate    = ang[15:0];
      c.speed   = spd[15:0];
      c.arrived = (root < longint'(arrive_thr));
      return c;
    endfunction

    function void note_pose(pose_t p);
      cmd_t c;
      c = steer_command(p);
      n_poses++;
      if (c.arrived) n_arrived++;
      if (c.rate == 16'sh7fff || c.rate == 16'sh8000) n_rate_sat++;
      if (c.speed == 16'hffff) n_speed_sat++;
      pending_cmds.push_back(c);
    endfunction

    function void check_cmd(cmd_t got);
      cmd_t want;
      n_cmds++;
      if (pending_cmds.size() == 0) begin
        n_errors++;
        $display("%0t: command with no pose pending: rate %0d speed %0d arrived %0d",
                 $time, got.rate, got.speed, got.arrived);
        return;
      end
      want = pending_cmds.pop_front();
      if (got.rate !== want.rate) begin
        n_errors++;
        $display("%0t: angular_rate mismatch: expected %0d, got %0d",
                 $time, want.rate, got.rate);
      end
      if (got.speed !== want.speed) begin
        n_errors++;
        $display("%0t: linear_speed mismatch: expected %0d, got %0d",
                 $time, want.speed, got.speed);
      end
      if (got.arrived !== want.arrived) begin
        n_errors++;
        $display("%0t: arrived mismatch: expected %0b, got %0b",
                 $time, want.arrived, got.arrived);
      end
    endfunction
  endclass

endpackage

// ===== bench/tb_top.sv =====
// Top-level bench for go_to_goal_velocity_controller: drives poses and register
// settings, checks every command. Depends on ggvc_pkg, the two channel interfaces
// and ggvc_bench_pkg.
`timescale 1ns / 100ps
module tb_top;
  import ggvc_pkg::*;
  import ggvc_bench_pkg::*;

  logic              clk_i;
  logic              rst_ni;
  logic              cfg_we_i;
  logic [CFG_IW-1:0] cfg_idx_i;
  logic [CFG_DW-1:0] cfg_data_i;
  int                src_idle_pct = 0;
  int                snk_idle_pct = 0;
  int                n_settings = 0;
  ggvc_scoreboard    sb;

  ggvc_pose_if pose_if ();
  ggvc_cmd_if  cmd_if ();

  go_to_goal_velocity_controller #(.CORDIC_STAGES(CORDIC_DEPTH)) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .pose_i     (pose_if),
    .cmd_o      (cmd_if)
  );

  initial begin
    clk_i = 1'b0;
    forever #1 clk_i = ~clk_i;
  end

  initial begin
    #400_000;
    $display("** go_to_goal_velocity_controller: FAILED **");
    $finish;
  end

  initial begin
    cmd_if.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      cmd_if.ready = ($urandom_range(99) >= snk_idle_pct);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && cmd_if.valid && cmd_if.ready)
      sb.check_cmd(cmd_t'{cmd_if.angular_rate, cmd_if.linear_speed, cmd_if.arrived});
  end

  function automatic logic signed [15:0] clip16(int v);
    if (v > 32767) return 16'sh7fff;
    if (v < -32768) return 16'sh8000;
    return v[15:0];
  endfunction

  function automatic pose_t random_pose();
    pose_t p;
    int    mode;
    mode = $urandom_range(7);
    p.x = 16'($urandom);
    p.y = 16'($urandom);
    case (mode)
      4, 5: begin
        p.x = clip16(int'(sb.tgt_x) + int'($urandom_range(128)) - 64);
        p.y = clip16(int'(sb.tgt_y) + int'($urandom_range(128)) - 64);
      end
      6: begin
        p.x = $urandom_range(1) ? 16'sh7fff : 16'sh8000;
        p.y = $urandom_range(1) ? 16'sh7fff : 16'sh8000;
      end
      7: begin
        if ($urandom_range(1)) p.x = sb.tgt_x;
        else p.y = sb.tgt_y;
      end
      default: ;
    endcase
    if ($urandom_range(1)) p.heading = 16'($urandom);
    else p.heading = 16'(int'($urandom_range(2048)) - 1024);
    return p;
  endfunction

  // call at a falling edge; returns at the falling edge after acceptance
  task automatic send_pose(input pose_t p);
    while ($urandom_range(99) < src_idle_pct) begin
      pose_if.valid = 1'b0;
      @(negedge clk_i);
    end
    pose_if.valid        = 1'b1;
    pose_if.pose_x       = p.x;
    pose_if.pose_y       = p.y;
    pose_if.pose_heading = p.heading;
    do @(posedge clk_i); while (!pose_if.ready);
    sb.note_pose(p);
    @(negedge clk_i);
  endtask

  task automatic drain();
    pose_if.valid = 1'b0;
    while (sb.pending_cmds.size() != 0) @(negedge clk_i);
    repeat (2) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IW-1:0] idx, input logic [CFG_DW-1:0] data);
    cfg_we_i   = 1'b1;
    cfg_idx_i  = idx;
    cfg_data_i = data;
    @(posedge clk_i);
    sb.write_reg(idx, data);
    @(negedge clk_i);
  endtask

  task automatic apply_setting(input int seg);
    int i;
    case (seg)
      0: begin
        write_reg(REG_TARGET_X, 16'h7fff);
        write_reg(REG_TARGET_Y, 16'h8000);
        write_reg(REG_ANGULAR_GAIN, 16'hffff);
        write_reg(REG_LINEAR_GAIN, 16'hffff);
        write_reg(REG_ARRIVE_THR, 16'hffff);
      end
      1: begin
        write_reg(REG_TARGET_X, 16'h8000);
        write_reg(REG_TARGET_Y, 16'h7fff);
        write_reg(REG_ANGULAR_GAIN, 16'h0000);
        write_reg(REG_LINEAR_GAIN, 16'h0000);
        write_reg(REG_ARRIVE_THR, 16'h0000);
      end
      default: begin
        write_reg(REG_TARGET_X, CFG_DW'($urandom));
        write_reg(REG_TARGET_Y, CFG_DW'($urandom));
        write_reg(REG_ANGULAR_GAIN, CFG_DW'($urandom));
        write_reg(REG_LINEAR_GAIN, CFG_DW'($urandom));
        write_reg(REG_ARRIVE_THR,
                  CFG_DW'($urandom_range(1) ? $urandom : $urandom_range(512)));
      end
    endcase
    // unmapped indexes must leave every register alone
    for (i = REG_ARRIVE_THR + 1; i < 2 ** CFG_IW; i++) write_reg(CFG_IW'(i), CFG_DW'($urandom));
    cfg_we_i = 1'b0;
    n_settings++;
  endtask

  initial begin
    int seg;
    sb = new();
    rst_ni               = 1'b0;
    cfg_we_i             = 1'b0;
    cfg_idx_i            = '0;
    cfg_data_i           = '0;
    pose_if.valid        = 1'b0;
    pose_if.pose_x       = '0;
    pose_if.pose_y       = '0;
    pose_if.pose_heading = '0;
    repeat (6) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    src_idle_pct = 30;
    snk_idle_pct = 85;
    send_pose('{16'sd0, 16'sd0, 16'sd0});
    send_pose('{16'sd0, 16'sd0, 16'sh7fff});
    send_pose('{16'sd0, 16'sd0, 16'sh8000});
    send_pose('{16'sd256, 16'sd0, 16'sd0});
    send_pose('{16'sd256, -16'sd1, 16'sd0});
    send_pose('{16'sd256, 16'sd1, 16'sd0});
    send_pose('{-16'sd256, 16'sd0, 16'sd0});
    send_pose('{16'sd0, -16'sd256, 16'sd0});
    send_pose('{16'sd0, 16'sd256, 16'sd0});
    send_pose('{16'sd25, 16'sd0, 16'sd0});
    send_pose('{16'sd26, 16'sd0, 16'sd0});
    send_pose('{16'sd0, -16'sd25, 16'sd0});
    send_pose('{16'sd18, 16'sd18, 16'sd0});
    send_pose('{-16'sd181, -16'sd181, 16'sd201});
    send_pose('{16'sh7fff, 16'sh7fff, 16'sd0});
    send_pose('{16'sh8000, 16'sh8000, 16'sh8000});
    send_pose('{16'sh8000, 16'sh7fff, 16'sh7fff});
    send_pose('{16'sh7fff, 16'sh8000, 16'sd0});
    send_pose('{16'sh5555, 16'shAAAA, 16'sh5555});
    send_pose('{16'shAAAA, 16'sh5555, 16'shAAAA});

    for (seg = 0; seg < 6; seg++) begin
      if (seg == 2) begin
        src_idle_pct = 85;
        snk_idle_pct = 30;
      end
      if (seg == 4) begin
        src_idle_pct = 0;
        snk_idle_pct = 0;
      end
      drain();
      apply_setting(seg);
      send_pose('{sb.tgt_x, sb.tgt_y, 16'sd0});
      send_pose('{16'sh7fff, 16'sh7fff, 16'sh7fff});
      send_pose('{16'sh8000, 16'sh8000, 16'sh8000});
      send_pose('{16'sh7fff, 16'sh8000, 16'sd0});
      send_pose('{16'sh8000, 16'sh7fff, 16'sd0});
      repeat (112) send_pose(random_pose());
    end

    drain();
    repeat (PIPE_LATENCY + 8) @(negedge clk_i);
    if (sb.pending_cmds.size() != 0) begin
      sb.n_errors += sb.pending_cmds.size();
      $display("%0t: %0d commands never arrived", $time, sb.pending_cmds.size());
    end
    $display("Checked %0d commands for %0d poses over %0d register settings.",
             sb.n_cmds, sb.n_poses, n_settings);
    $display("Arrived %0d, turn rate saturated %0d, speed saturated %0d, errors %0d.",
             sb.n_arrived, sb.n_rate_sat, sb.n_speed_sat, sb.n_errors);
    if (sb.n_errors == 0) begin
      $display("** go_to_goal_velocity_controller: PASSED **");
    end else begin
      $display("** go_to_goal_velocity_controller: FAILED **");
    end
    $finish;
  end

endmodule
